[rtl/cpts_pkg.sv]
`default_nettype none
// ============================================================================
// cpts_pkg
// Shared types, widths and command codes of the time-slice task scheduler.
// ============================================================================
package cpts_pkg;

    localparam int unsigned NUM_SLOTS_DEF = 64;
    localparam int unsigned CNT_W         = 9;
    localparam int unsigned PRIO_W        = 8;
    localparam int unsigned CMD_W         = 2;
    localparam int unsigned OUT_IDX_W     = 6;
    localparam int unsigned S_TDATA_W     = 16;
    localparam int unsigned S_TUSER_W     = 2;
    localparam int unsigned M_TDATA_W     = 16;

    localparam logic [PRIO_W-1:0] FIRST_PRIO_RESET = 8'd1;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_YIELD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EXIT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CREATE = 2'd3;

    // one command item
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic              preempt_blocked;
        logic [PRIO_W-1:0] new_priority;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [OUT_IDX_W-1:0] current_task;
        logic                 switched;
        logic [OUT_IDX_W-1:0] created_slot;
        logic                 create_failed;
    } res_t;

    // one slot entry of the slot memory
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]  cnt;
        logic              run;
    } slot_word_t;

    localparam int unsigned SLOT_WORD_W = PRIO_W + CNT_W + 1;

endpackage
`default_nettype wire

[rtl/cpts_ram.sv]
`default_nettype none
// ============================================================================
// cpts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module cpts_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/cpts_engine.sv]
`default_nettype none
// ============================================================================
// cpts_engine
// Command sequencer: fill count, slot memory and the scan / recharge passes.
// ============================================================================
module cpts_engine #(
    parameter int unsigned NUM_SLOTS = cpts_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [cpts_pkg::PRIO_W-1:0]   first_prio,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire cpts_pkg::cmd_t                in_cmd,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output cpts_pkg::res_t                     res
);

    localparam int unsigned IDX_W = $clog2(NUM_SLOTS);
    localparam int unsigned PTR_W = IDX_W + 1;
    localparam int unsigned CNT_W = cpts_pkg::CNT_W;
    localparam int unsigned OUT_W = cpts_pkg::OUT_IDX_W;
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(NUM_SLOTS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CUR  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_RECH = 3'd3;
    localparam logic [2:0] ST_FREE = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]           state_reg, state_next;
    cpts_pkg::cmd_t       cmd_reg, cmd_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic [IDX_W-1:0]     before_reg, before_next;
    logic [PTR_W-1:0]     fill_reg, fill_next;
    logic                 s0_valid_reg, s0_valid_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic                 pv_reg, pv_next;
    logic [IDX_W-1:0]     pidx_reg, pidx_next;
    logic                 found_reg, found_next;
    logic [CNT_W-1:0]     top_reg, top_next;
    logic [IDX_W-1:0]     best_reg, best_next;
    logic                 recharged_reg, recharged_next;
    logic [IDX_W-1:0]     created_reg, created_next;
    logic                 failed_reg, failed_next;

    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    cpts_pkg::slot_word_t         mem_wdata;
    logic [IDX_W-1:0]             mem_raddr;
    cpts_pkg::slot_word_t         rd_word;

    logic [CNT_W-1:0]             eff_cnt;
    logic                         eff_run;
    logic                         in_fill;
    logic [CNT_W-1:0]             tick_cnt;
    logic [CNT_W-1:0]             new_cnt;
    logic [cpts_pkg::PRIO_W-1:0]  prio_eff;
    logic [CNT_W-1:0]             recharge_cnt;
    logic                         issue;
    logic                         pass_end;

    cpts_ram #(
        .WIDTH (cpts_pkg::SLOT_WORD_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_word)
    );

    // slot 0 reads as running with a zero count until first written
    assign eff_cnt  = (pidx_reg == '0 && !s0_valid_reg) ? '0 : rd_word.cnt;
    assign eff_run  = (pidx_reg == '0 && !s0_valid_reg) ? 1'b1 : rd_word.run;
    // slots are never freed and creates take the lowest free one, so the
    // used slots are always 0 .. fill_reg - 1
    assign in_fill  = ({1'b0, pidx_reg} < fill_reg);
    assign tick_cnt = (eff_cnt == '0) ? '0 : eff_cnt - CNT_W'(1);
    assign new_cnt  = (cmd_reg.command == cpts_pkg::CMD_TICK) ? tick_cnt : '0;
    assign prio_eff = (pidx_reg == '0) ? first_prio : rd_word.prio;
    // half count plus priority stays below 511, no saturation needed
    assign recharge_cnt = {1'b0, eff_cnt[CNT_W-1:1]} + CNT_W'(prio_eff);
    assign issue    = (ptr_reg != PTR_END);
    assign pass_end = !issue && !pv_reg;

    assign in_ready            = (state_reg == ST_IDLE);
    assign res_valid           = (state_reg == ST_DONE);
    assign res.current_task    = OUT_W'(cur_reg);
    assign res.switched        = (cur_reg != before_reg);
    assign res.created_slot    = OUT_W'(created_reg);
    assign res.create_failed   = failed_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cur_next       = cur_reg;
        before_next    = before_reg;
        fill_next      = fill_reg;
        s0_valid_next  = s0_valid_reg;
        ptr_next       = ptr_reg;
        pv_next        = pv_reg;
        pidx_next      = pidx_reg;
        found_next     = found_reg;
        top_next       = top_reg;
        best_next      = best_reg;
        recharged_next = recharged_reg;
        created_next   = created_reg;
        failed_next    = failed_reg;
        mem_we         = 1'b0;
        mem_waddr      = pidx_reg;
        mem_wdata      = '0;
        mem_raddr      = ptr_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = cur_reg;
                if (in_valid)
                begin
                    cmd_next     = in_cmd;
                    before_next  = cur_reg;
                    created_next = '0;
                    failed_next  = 1'b0;
                    if (in_cmd.command == cpts_pkg::CMD_CREATE)
                    begin
                        state_next = ST_FREE;
                    end
                    else
                    begin
                        pidx_next  = cur_reg;
                        state_next = ST_CUR;
                    end
                end
            end

            ST_CUR:
            begin
                mem_we        = 1'b1;
                mem_wdata.prio = rd_word.prio;
                mem_wdata.cnt  = new_cnt;
                mem_wdata.run  = (cmd_reg.command == cpts_pkg::CMD_EXIT) ? 1'b0 : eff_run;
                if (pidx_reg == '0)
                begin
                    s0_valid_next = 1'b1;
                end
                if (cmd_reg.command == cpts_pkg::CMD_TICK &&
                    (new_cnt != '0 || cmd_reg.preempt_blocked))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    ptr_next       = '0;
                    pv_next        = 1'b0;
                    found_next     = 1'b0;
                    top_next       = '0;
                    best_next      = '0;
                    recharged_next = 1'b0;
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                pv_next = issue;
                if (issue)
                begin
                    ptr_next  = ptr_reg + PTR_W'(1);
                    pidx_next = ptr_reg[IDX_W-1:0];
                end
                if (pv_reg && in_fill && eff_run &&
                    (!found_reg || eff_cnt > top_reg))
                begin
                    found_next = 1'b1;
                    top_next   = eff_cnt;
                    best_next  = pidx_reg;
                end
                if (pass_end)
                begin
                    if (found_reg && top_reg == '0 && !recharged_reg)
                    begin
                        ptr_next   = '0;
                        state_next = ST_RECH;
                    end
                    else
                    begin
                        cur_next   = found_reg ? best_reg : '0;
                        state_next = ST_DONE;
                    end
                end
            end

            ST_RECH:
            begin
                pv_next = issue;
                if (issue)
                begin
                    ptr_next  = ptr_reg + PTR_W'(1);
                    pidx_next = ptr_reg[IDX_W-1:0];
                end
                if (pv_reg && in_fill)
                begin
                    mem_we         = 1'b1;
                    mem_wdata.prio = rd_word.prio;
                    mem_wdata.cnt  = recharge_cnt;
                    mem_wdata.run  = eff_run;
                    if (pidx_reg == '0)
                    begin
                        s0_valid_next = 1'b1;
                    end
                end
                if (pass_end)
                begin
                    ptr_next       = '0;
                    found_next     = 1'b0;
                    top_next       = '0;
                    best_next      = '0;
                    recharged_next = 1'b1;
                    state_next     = ST_SCAN;
                end
            end

            ST_FREE:
            begin
                if (fill_reg == PTR_END)
                begin
                    failed_next = 1'b1;
                end
                else
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = fill_reg[IDX_W-1:0];
                    mem_wdata.prio = cmd_reg.new_priority;
                    mem_wdata.cnt  = CNT_W'(cmd_reg.new_priority);
                    mem_wdata.run  = 1'b1;
                    fill_next      = fill_reg + PTR_W'(1);
                    created_next   = fill_reg[IDX_W-1:0];
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_reg       <= '0;
            fill_reg      <= PTR_W'(1);
            s0_valid_reg  <= 1'b0;
            pv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            fill_reg      <= fill_next;
            s0_valid_reg  <= s0_valid_next;
            pv_reg        <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        before_reg    <= before_next;
        ptr_reg       <= ptr_next;
        pidx_reg      <= pidx_next;
        found_reg     <= found_next;
        top_reg       <= top_next;
        best_reg      <= best_next;
        recharged_reg <= recharged_next;
        created_reg   <= created_next;
        failed_reg    <= failed_next;
    end

`ifndef SYNTHESIS
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != '0 && fill_reg <= PTR_END)
        else $error("slot fill count out of range");

    a_cur_used: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, cur_reg} < fill_reg)
        else $error("current task points at a free slot");

    a_fail_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && failed_reg) |-> (fill_reg == PTR_END))
        else $error("create failed while a slot was free");

    a_create_no_switch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && cur_reg != before_reg) |->
        (cmd_reg.command != cpts_pkg::CMD_CREATE))
        else $error("create changed the current task");
`endif

endmodule
`default_nettype wire

[rtl/counter_priority_task_scheduler_top.sv]
`default_nettype none
// ============================================================================
// counter_priority_task_scheduler_top
// Time-slice task scheduler with per-slot counters and priorities.
// ============================================================================
//
// channel   direction  handshake          payload
// --------  ---------  -----------------  ------------------------------------
// s_*       in         s_tvalid/s_tready  tuser: command; tdata: preempt,
//                                          new_priority
// m_*       out        m_tvalid/m_tready  tdata: current_task, switched,
//                                          created_slot, create_failed
// cfg_*     in         cfg_wen            cfg_wdata: first_task_priority
//
// A tick that keeps the current task needs no scan, nor does a create (the
// fill count names the free slot at once); a reschedule scans every slot,
// and when all counters are spent a recharge pass and a second scan follow.
// The single read port of the slot memory, one entry a cycle, sets the scans.
// Reset: slot 0 is used, running and current; all counters read as zero.
// A held result in the output register does not stall the next item; the
// engine waits only if it finishes while that register is full and stalled.
//
module counter_priority_task_scheduler_top #(
    parameter int unsigned NUM_SLOTS = cpts_pkg::NUM_SLOTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration: first_task_priority
    input  wire logic                             cfg_wen,
    input  wire logic [cpts_pkg::PRIO_W-1:0]      cfg_wdata,
    // command items
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [0] preempt_blocked, [8:1] new_priority, [15:9] zero
    input  wire logic [cpts_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] command
    input  wire logic [cpts_pkg::S_TUSER_W-1:0]   s_tuser,
    // result items
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [5:0] current_task, [6] switched, [12:7] created_slot,
    // [13] create_failed, [15:14] zero
    output logic [cpts_pkg::M_TDATA_W-1:0]        m_tdata
);

    localparam int unsigned PRIO_W = cpts_pkg::PRIO_W;
    localparam int unsigned M_W    = cpts_pkg::M_TDATA_W;

    logic [PRIO_W-1:0]   first_prio_reg;
    cpts_pkg::cmd_t      in_cmd;
    logic                res_valid;
    logic                res_ready;
    cpts_pkg::res_t      res;
    logic                m_valid_reg, m_valid_next;
    logic [M_W-1:0]      m_data_reg, m_data_next;

    // user writes slot 0 priority only while the block is idle; not enforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_prio_reg <= cpts_pkg::FIRST_PRIO_RESET;
        end
        else if (cfg_wen)
        begin
            first_prio_reg <= cfg_wdata;
        end
    end

    // unpack the incoming item
    assign in_cmd.command         = s_tuser[cpts_pkg::CMD_W-1:0];
    assign in_cmd.preempt_blocked = s_tdata[0];
    assign in_cmd.new_priority    = s_tdata[PRIO_W:1];

    cpts_engine #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .first_prio (first_prio_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_cmd     (in_cmd),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // output register: take a new result when empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        priority if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_data_next  = M_W'({res.create_failed, res.created_slot,
                                 res.switched, res.current_task});
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

[dv/counter_priority_task_scheduler_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler_top_test
// Self-checking bench for the time-slice task scheduler. It streams tick,
// yield, exit and create commands under random back-pressure, keeps its own
// model of the slot table and compares every result item field by field.
// ----------------------------------------------------------------------------

// Slot-table model and store of awaited result items.
class slice_schedule_board;

    localparam int unsigned SLOTS     = cpts_pkg::NUM_SLOTS_DEF;
    localparam int unsigned COUNT_TOP = 511;

    bit                          used       [SLOTS];
    bit                          live       [SLOTS];
    logic [cpts_pkg::CNT_W-1:0]  slice_left [SLOTS];
    logic [cpts_pkg::PRIO_W-1:0] prio       [SLOTS];
    int unsigned                 current_slot;
    logic [cpts_pkg::PRIO_W-1:0] first_prio;

    cpts_pkg::res_t outcomes [$];
    int unsigned    errors;
    int unsigned    checked;

    function new();
        foreach (used[s])
        begin
            used[s]       = 1'b0;
            live[s]       = 1'b0;
            slice_left[s] = '0;
            prio[s]       = '0;
        end
        used[0]      = 1'b1;
        live[0]      = 1'b1;
        current_slot = 0;
        first_prio   = cpts_pkg::FIRST_PRIO_RESET;
        errors       = 0;
        checked      = 0;
    endfunction

    function void set_first_prio(logic [cpts_pkg::PRIO_W-1:0] v);
        first_prio = v;
    endfunction

    function int unsigned pending();
        return outcomes.size();
    endfunction

    // Busiest running slot, lowest index on ties. Returns 1 when it is spent.
    function bit find_busiest(output int unsigned best);
        bit                         found;
        logic [cpts_pkg::CNT_W-1:0] top;
        found = 1'b0;
        top   = '0;
        best  = 0;
        for (int unsigned s = 0; s < SLOTS; s++)
        begin
            if (used[s] && live[s] && (!found || slice_left[s] > top))
            begin
                found = 1'b1;
                top   = slice_left[s];
                best  = s;
            end
        end
        return found && top == 0;
    endfunction

    function void reschedule();
        int unsigned best;
        int unsigned v;
        if (find_busiest(best))
        begin
            // every counter spent: recharge all used slots, then pick again
            for (int unsigned s = 0; s < SLOTS; s++)
            begin
                if (used[s])
                begin
                    v = 32'(slice_left[s] >> 1);
                    v += 32'((s == 0) ? first_prio : prio[s]);
                    slice_left[s] = cpts_pkg::CNT_W'((v > COUNT_TOP) ? COUNT_TOP : v);
                end
            end
            void'(find_busiest(best));
        end
        current_slot = best;
    endfunction

    // Apply one accepted command and queue the result item it causes.
    function void take_command(logic [cpts_pkg::CMD_W-1:0] op, logic hold,
                               logic [cpts_pkg::PRIO_W-1:0] np);
        int unsigned    was;
        int unsigned    made;
        bit             failed;
        cpts_pkg::res_t want;
        if (current_slot >= SLOTS)
            current_slot = 0;
        was    = current_slot;
        made   = 0;
        failed = 1'b0;
        case (op)
            cpts_pkg::CMD_TICK:
            begin
                if (slice_left[current_slot] != 0)
                    slice_left[current_slot]--;
                if (slice_left[current_slot] == 0 && !hold)
                    reschedule();
            end
            cpts_pkg::CMD_YIELD:
            begin
                slice_left[current_slot] = '0;
                reschedule();
            end
            cpts_pkg::CMD_EXIT:
            begin
                live[current_slot]       = 1'b0;
                slice_left[current_slot] = '0;
                reschedule();
            end
            default:
            begin
                failed = 1'b1;
                for (int unsigned s = 0; s < SLOTS; s++)
                begin
                    if (!used[s])
                    begin
                        used[s]       = 1'b1;
                        live[s]       = 1'b1;
                        prio[s]       = np;
                        slice_left[s] = cpts_pkg::CNT_W'(np);
                        made          = s;
                        failed        = 1'b0;
                        break;
                    end
                end
            end
        endcase
        want.current_task  = current_slot[cpts_pkg::OUT_IDX_W-1:0];
        want.switched      = (current_slot != was);
        want.created_slot  = made[cpts_pkg::OUT_IDX_W-1:0];
        want.create_failed = failed;
        outcomes.push_back(want);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            errors++;
            if (errors <= 10)
                $display("result %0d: %s expected %0d, got %0d", checked, field, want, got);
        end
    endfunction

    // Check one accepted result item against the oldest awaited one.
    function void match_result(logic [cpts_pkg::M_TDATA_W-1:0] d);
        cpts_pkg::res_t want;
        checked++;
        if (outcomes.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("result %0d: item 0x%h arrived with nothing awaited", checked, d);
            return;
        end
        want = outcomes.pop_front();
        compare("current_task", want.current_task, d[5:0]);
        compare("switched", want.switched, d[6]);
        compare("created_slot", want.created_slot, d[12:7]);
        compare("create_failed", want.create_failed, d[13]);
    endfunction

endclass

module counter_priority_task_scheduler_top_test;

    localparam int unsigned PRIO_W    = cpts_pkg::PRIO_W;
    localparam int unsigned CMD_W     = cpts_pkg::CMD_W;
    localparam int unsigned S_TDATA_W = cpts_pkg::S_TDATA_W;
    localparam int unsigned S_TUSER_W = cpts_pkg::S_TUSER_W;
    localparam int unsigned M_TDATA_W = cpts_pkg::M_TDATA_W;

    // Block size and timing settings of the bench.
    localparam int unsigned SLOTS         = cpts_pkg::NUM_SLOTS_DEF;
    localparam int unsigned LATENCY       = 3 * SLOTS + 9;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_CYCLES  = 2 * LATENCY;
    localparam int unsigned PHASES        = 5;
    localparam int unsigned PHASE_ITEMS   = 120;
    // Long receiver hold-off, placed away from the configuration phase edges.
    localparam int unsigned HOLD_AT       = 320;
    localparam int unsigned HOLD_CYCLES   = 1500;
    localparam int unsigned LIMIT_CYCLES  = 1_500_000;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [PRIO_W-1:0]    cfg_wdata = cpts_pkg::FIRST_PRIO_RESET;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [S_TUSER_W-1:0] s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    slice_schedule_board board = new();

    int unsigned cycle_count = 0;
    // Items still to be sent back to back, with no gap.
    int unsigned calm_items  = 0;

    counter_priority_task_scheduler_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sender gap before the next item: mostly none or short, now and then
    // long, and sometimes a run of back-to-back items.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm_items != 0)
        begin
            calm_items--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 4)
        begin
            calm_items = $urandom_range(10, 30);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one command, hold it until accepted, note it, then idle a while.
    // With a zero gap tvalid stays high into the next item.
    task automatic send_cmd(input logic [CMD_W-1:0] op, input logic hold,
                            input logic [PRIO_W-1:0] np);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - PRIO_W - 1){1'b0}}, np, hold};
        do
            @(posedge clk);
        while (!s_tready);
        board.take_command(op, hold, np);
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random command: mostly ticks and yields, creates often enough to fill
    // the table well into the run, exits rare. Priorities lean small so that
    // counters drain and recharges happen often.
    task automatic send_random();
        int unsigned       roll;
        logic [CMD_W-1:0]  op;
        logic [PRIO_W-1:0] np;
        logic              hold;
        roll = $urandom_range(99);
        if (roll < 58)
            op = cpts_pkg::CMD_TICK;
        else if (roll < 84)
            op = cpts_pkg::CMD_YIELD;
        else if (roll < 87)
            op = cpts_pkg::CMD_EXIT;
        else
            op = cpts_pkg::CMD_CREATE;
        if ($urandom_range(9) < 7)
            np = PRIO_W'($urandom_range(1, 12));
        else
            np = PRIO_W'($urandom_range(1, 255));
        hold = ($urandom_range(3) == 0);
        send_cmd(op, hold, np);
    endtask

    // Drop tvalid and wait until every awaited result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write first_task_priority while the block is idle.
    task automatic write_first_prio(input logic [PRIO_W-1:0] v);
        settle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        board.set_first_prio(v);
    endtask

    // Result side: check every accepted item, then decide tready for the
    // next edge. Short random stalls, calm stretches with tready held high,
    // and one long hold-off that lets the block fill up and stall its input.
    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned calm_left;
        int unsigned results_seen;
        int unsigned roll;
        stall_left   = 0;
        calm_left    = 0;
        results_seen = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                board.match_result(m_tdata);
                results_seen++;
                if (results_seen == HOLD_AT)
                    stall_left = HOLD_CYCLES;
            end
            if (stall_left != 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (calm_left != 0)
                    calm_left--;
                else
                begin
                    roll = $urandom_range(99);
                    if (roll < 2)
                        calm_left = $urandom_range(100, 300);
                    else if (roll < 14)
                        stall_left = $urandom_range(1, 4);
                    else if (roll < 17)
                        stall_left = $urandom_range(20, 60);
                end
            end
        end
    end

    // Hard stop: a run that hangs ends here as a failure.
    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        logic [PRIO_W-1:0] phase_prio [PHASES];
        phase_prio = '{8'd3, 8'd255, 8'd64, 8'd1, 8'd200};
        phase_prio[2] = PRIO_W'($urandom_range(1, 255));

        // Hold reset, then release it for good.
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, slot 0 at the top priority first.
        write_first_prio(8'd255);
        send_cmd(cpts_pkg::CMD_TICK, 1'b0, 8'd1);      // spent counter: recharge slot 0
        send_cmd(cpts_pkg::CMD_TICK, 1'b1, 8'd1);      // blocked tick, counter nonzero
        send_cmd(cpts_pkg::CMD_YIELD, 1'b0, 8'd255);   // lone task yields to itself
        send_cmd(cpts_pkg::CMD_CREATE, 1'b0, 8'd255);  // priority extremes, bit patterns
        send_cmd(cpts_pkg::CMD_CREATE, 1'b1, 8'd1);
        send_cmd(cpts_pkg::CMD_CREATE, 1'b0, 8'h80);
        send_cmd(cpts_pkg::CMD_CREATE, 1'b0, 8'h7f);
        send_cmd(cpts_pkg::CMD_YIELD, 1'b1, 8'd2);     // switch to the busiest new slot
        send_cmd(cpts_pkg::CMD_TICK, 1'b1, 8'd3);
        send_cmd(cpts_pkg::CMD_TICK, 1'b0, 8'd4);
        send_cmd(cpts_pkg::CMD_EXIT, 1'b0, 8'd5);      // current task turns zombie
        send_cmd(cpts_pkg::CMD_YIELD, 1'b0, 8'd6);

        // Same table under the lowest slot 0 priority.
        write_first_prio(8'd1);
        send_cmd(cpts_pkg::CMD_YIELD, 1'b0, 8'd1);
        send_cmd(cpts_pkg::CMD_YIELD, 1'b1, 8'd1);
        send_cmd(cpts_pkg::CMD_CREATE, 1'b0, 8'd2);
        send_cmd(cpts_pkg::CMD_TICK, 1'b0, 8'd1);
        send_cmd(cpts_pkg::CMD_TICK, 1'b0, 8'd1);
        send_cmd(cpts_pkg::CMD_TICK, 1'b1, 8'd1);      // blocked tick, counter stays nonzero
        send_cmd(cpts_pkg::CMD_TICK, 1'b0, 8'd1);
        send_cmd(cpts_pkg::CMD_EXIT, 1'b1, 8'd7);
        send_cmd(cpts_pkg::CMD_YIELD, 1'b0, 8'd9);
        send_cmd(cpts_pkg::CMD_YIELD, 1'b0, 8'd9);

        // Random part in phases; each phase starts from an idle block with a
        // new slot 0 priority. The table fills up along the way, so creates
        // late in the run find no free slot.
        for (int unsigned p = 0; p < PHASES; p++)
        begin
            write_first_prio(phase_prio[p]);
            repeat (PHASE_ITEMS) send_random();
        end

        // Retire every task so that no running slot is left, then poke the
        // empty table: the pick falls back to slot 0 and creates fail.
        settle();
        repeat (SLOTS) send_cmd(cpts_pkg::CMD_EXIT, 1'($urandom_range(1)), 8'd1);
        send_cmd(cpts_pkg::CMD_TICK, 1'b0, 8'd1);
        send_cmd(cpts_pkg::CMD_YIELD, 1'b0, 8'd1);
        send_cmd(cpts_pkg::CMD_CREATE, 1'b0, 8'd42);
        send_cmd(cpts_pkg::CMD_EXIT, 1'b0, 8'd1);
        send_cmd(cpts_pkg::CMD_TICK, 1'b1, 8'd1);

        // Drain, then give stray results a chance to show up.
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
